// ===== hw/rtl/bslu_pkg.sv =====
// Shared types and constants for the bracketed string list unescaper.
package bslu_pkg;

  localparam int unsigned TextCapacity = 8192;
  localparam int unsigned CntW         = $clog2(TextCapacity + 1);
  localparam int unsigned TextLenW     = 14;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned OutDataW     = 24;

  localparam logic [ByteW-1:0] ChOpenBracket  = 8'h5B;
  localparam logic [ByteW-1:0] ChCloseBracket = 8'h5D;
  localparam logic [ByteW-1:0] ChOpenParen    = 8'h28;
  localparam logic [ByteW-1:0] ChCloseParen   = 8'h29;
  localparam logic [ByteW-1:0] ChBackslash    = 8'h5C;
  localparam logic [ByteW-1:0] ChZero         = 8'h30;
  localparam logic [ByteW-1:0] ChNine         = 8'h39;
  localparam logic [ByteW-1:0] ChNewline      = 8'h0A;
  localparam logic [ByteW-1:0] ChSpace        = 8'h20;
  localparam logic [ByteW-1:0] ChTab          = 8'h09;
  localparam logic [ByteW-1:0] ChCr           = 8'h0D;

  typedef enum logic [2:0] {
    PhSeekBracket = 3'd0,
    PhBetween     = 3'd1,
    PhSeekParen   = 3'd2,
    PhString      = 3'd3,
    PhEscape      = 3'd4,
    PhOctal1      = 3'd5,
    PhOctal2      = 3'd6
  } phase_e;

  typedef struct packed {
    logic             overflowed;
    logic [TextLenW-1:0] text_length;
    logic [ByteW-1:0] text_char;
  } out_fields_t;

endpackage

// ===== hw/rtl/bracketed_string_list_unescaper_core.sv =====
// Bracketed string list unescaper: input register, parser, result register.
//
// Channel  Dir  Handshake                    tdata / tuser
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: byte_value; tuser: end_of_data
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: text_char, text_length, overflowed
//                                            tuser: finished
// cfg      in   cfg_valid_i/cfg_ready_o      cfg_data_i: escape_mode
//
// One byte per clock unless the result register stalls: the parser's next
// state is computed between the input register and the result register.
// Reset clears the parser state and sets escape_mode to 1.
// A stalled result register holds the input register; input stalls then.
module bracketed_string_list_unescaper_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bslu_pkg::ByteW-1:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic                        s_axis_tuser,  // [0] end_of_data
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] text_char, [21:8] text_length, [22] overflowed, [23] zero
  output logic [bslu_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                        m_axis_tuser,  // [0] finished
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i     // [0] escape_mode
);
  import bslu_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_eod_q;
  logic             adv;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] acc_q, acc_d;
  logic             nl_q, nl_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             mode_q;

  logic             out_valid_q;
  logic             out_fin_q;
  out_fields_t      out_q, out_d;
  logic             out_valid_d;

  logic             emit_req, finish, clr, is_blank, is_digit, room;
  logic [ByteW-1:0] emit_char, byte_off, acc_shift;

  assign cfg_ready_o   = 1'b1;
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  assign is_blank  = (in_byte_q == ChSpace) || ((in_byte_q >= ChTab) && (in_byte_q <= ChCr));
  assign is_digit  = (in_byte_q >= ChZero) && (in_byte_q <= ChNine);
  assign byte_off  = in_byte_q - ChZero;
  assign acc_shift = {acc_q[ByteW-4:0], 3'b000} + byte_off;
  assign room      = (cnt_q < CntW'(TextCapacity));

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (in_eod_q) begin
      phase_d = PhSeekBracket;
    end else begin
      unique case (phase_q)
        PhSeekBracket: if (in_byte_q == ChOpenBracket) phase_d = PhBetween;
        PhBetween: begin
          if (is_blank) phase_d = PhBetween;
          else if (in_byte_q == ChCloseBracket) phase_d = PhSeekBracket;
          else if (in_byte_q == ChOpenParen) phase_d = PhString;
          else phase_d = PhSeekParen;
        end
        PhSeekParen: if (in_byte_q == ChOpenParen) phase_d = PhString;
        PhString: begin
          if (in_byte_q == ChCloseParen) phase_d = PhBetween;
          else if (in_byte_q == ChBackslash) phase_d = PhEscape;
        end
        PhEscape: phase_d = (mode_q && is_digit) ? PhOctal1 : PhString;
        PhOctal1: phase_d = PhOctal2;
        PhOctal2: phase_d = PhString;
        default:  phase_d = PhSeekBracket;
      endcase
    end
  end

  // Actions per phase
  always_comb begin
    emit_req  = 1'b0;
    emit_char = in_byte_q;
    finish    = 1'b0;
    clr       = 1'b0;
    acc_d     = acc_q;
    nl_d      = nl_q;
    if (in_eod_q) begin
      finish = 1'b1;
    end else begin
      unique case (phase_q)
        PhSeekBracket: ;
        PhBetween: begin
          if (!is_blank && in_byte_q == ChCloseBracket) begin
            finish = 1'b1;
          end else if (!is_blank && in_byte_q == ChOpenParen && nl_q) begin
            nl_d      = 1'b0;
            emit_req  = 1'b1;
            emit_char = ChNewline;
          end
        end
        PhSeekParen: begin
          if (in_byte_q == ChOpenParen && nl_q) begin
            nl_d      = 1'b0;
            emit_req  = 1'b1;
            emit_char = ChNewline;
          end
        end
        PhString: begin
          if (in_byte_q == ChCloseParen) nl_d = 1'b1;
          else if (in_byte_q != ChBackslash) emit_req = 1'b1;
        end
        PhEscape: begin
          if (mode_q && is_digit) acc_d = byte_off;
          else emit_req = 1'b1;
        end
        PhOctal1: acc_d = acc_shift;
        PhOctal2: begin
          acc_d     = acc_shift;
          emit_req  = 1'b1;
          emit_char = acc_shift;
        end
        default: clr = 1'b1;
      endcase
    end
  end

  // Count, overflow and result
  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = 1'b0;
      out_d.overflowed  = ovf_q;
      out_d.text_length = TextLenW'(cnt_q);
      out_d.text_char   = '0;
      if (finish) begin
        out_valid_d = 1'b1;
        cnt_d       = '0;
        ovf_d       = 1'b0;
      end else if (clr) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (emit_req) begin
        if (room) begin
          cnt_d             = cnt_q + 1'b1;
          out_valid_d       = 1'b1;
          out_d.text_char   = emit_char;
          out_d.text_length = TextLenW'(cnt_q + 1'b1);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PhSeekBracket;
      acc_q       <= '0;
      nl_q        <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      mode_q      <= 1'b1;
      out_valid_q <= 1'b0;
      out_fin_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      if (adv) begin
        out_fin_q <= finish;
        if (finish || clr) begin
          phase_q <= PhSeekBracket;
          acc_q   <= '0;
          nl_q    <= 1'b0;
        end else begin
          phase_q <= phase_d;
          acc_q   <= acc_d;
          nl_q    <= nl_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eod_q  <= s_axis_tuser;
    end
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_fin_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(out_fields_t)){1'b0}}, out_q};

endmodule
